@@ sv/wdf_pkg.sv @@
// shared types and constants for the word divide with flags pipeline
package wdf_pkg;

    localparam int WORD_W          = 16;
    localparam int LONG_W          = 32;
    localparam int FLAGS_W         = 4;
    localparam int STEPS_PER_STAGE = 2;
    localparam int NUM_STEP_STAGES = WORD_W / STEPS_PER_STAGE;
    localparam int S_TDATA_W       = 56;
    localparam int M_TDATA_W       = 40;

    // condition code bit positions
    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_V = 1;
    localparam int FLAG_C = 0;

    // divide kinds carried on tuser
    localparam logic KIND_UNSIGNED = 1'b0;
    localparam logic KIND_SIGNED   = 1'b1;

    // signed quotient magnitude limits
    localparam logic [WORD_W-1:0] QPOS_MAX = 16'h7fff;
    localparam logic [WORD_W-1:0] QNEG_MAX = 16'h8000;

    // word state carried down the pipeline
    typedef struct packed {
        logic                is_signed;
        logic                dneg;
        logic                qneg;
        logic                dz;
        logic                ovf_hi;
        logic [FLAGS_W-1:0]  flags;
        logic [WORD_W-1:0]   rem;
        logic [WORD_W-1:0]   lo;
        logic [WORD_W-1:0]   us;
    } wdf_item_t;

endpackage

@@ sv/wdf_prep.sv @@
// input stage: operand magnitudes, zero divisor and high word overflow check
module wdf_prep
    import wdf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 kind,
    input  logic [LONG_W-1:0]    dividend,
    input  logic [WORD_W-1:0]    divisor,
    input  logic [FLAGS_W-1:0]   flags_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output wdf_item_t            out_item
);

    logic                valid_reg;
    wdf_item_t           item_reg;
    wdf_item_t           item_next;
    logic                dneg;
    logic                sneg;
    logic [LONG_W-1:0]   ud;
    logic [WORD_W-1:0]   us;

    // magnitudes and sign bookkeeping
    always_comb begin
        dneg = (kind == KIND_SIGNED) && dividend[LONG_W-1];
        sneg = (kind == KIND_SIGNED) && divisor[WORD_W-1];
        ud   = dneg ? (LONG_W'(0) - dividend) : dividend;
        us   = sneg ? (WORD_W'(0) - divisor) : divisor;
        item_next.is_signed = (kind == KIND_SIGNED);
        item_next.dneg      = dneg;
        item_next.qneg      = dneg ^ sneg;
        item_next.dz        = (divisor == '0);
        // quotient needs more than 16 bits when the high word reaches the divisor
        item_next.ovf_hi    = (ud[LONG_W-1:WORD_W] >= us);
        item_next.flags     = flags_in;
        item_next.rem       = ud[LONG_W-1:WORD_W];
        item_next.lo        = ud[WORD_W-1:0];
        item_next.us        = us;
    end

    assign in_ready = !valid_reg || out_ready;

    // stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ sv/wdf_step.sv @@
// one pipeline stage of restoring division, two quotient bits per stage
module wdf_step
    import wdf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  wdf_item_t  in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output wdf_item_t  out_item
);

    logic        valid_reg;
    wdf_item_t   item_reg;
    wdf_item_t   item_next;

    // shift in the next dividend bit, subtract when the divisor fits
    always_comb begin
        logic [WORD_W:0] part;
        logic [WORD_W:0] diff;
        item_next = in_item;
        for (int i = 0; i < STEPS_PER_STAGE; i++) begin
            part = {item_next.rem, item_next.lo[WORD_W-1]};
            diff = part - {1'b0, item_next.us};
            if (part >= {1'b0, item_next.us}) begin
                item_next.rem = diff[WORD_W-1:0];
                item_next.lo  = {item_next.lo[WORD_W-2:0], 1'b1};
            end else begin
                item_next.rem = part[WORD_W-1:0];
                item_next.lo  = {item_next.lo[WORD_W-2:0], 1'b0};
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ sv/wdf_fin.sv @@
// output stage: sign correction, range check, condition codes, output register
module wdf_fin
    import wdf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  wdf_item_t           in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [LONG_W-1:0]   result,
    output logic                write_reg,
    output logic [FLAGS_W-1:0]  flags_out,
    output logic                divide_by_zero
);

    logic                valid_reg;
    logic [LONG_W-1:0]   result_reg;
    logic [LONG_W-1:0]   result_next;
    logic                write_reg_reg;
    logic                write_reg_next;
    logic [FLAGS_W-1:0]  flags_reg;
    logic [FLAGS_W-1:0]  flags_next;
    logic                dz_reg;
    logic                dz_next;
    logic                ovf;
    logic [WORD_W-1:0]   quot;
    logic [WORD_W-1:0]   rem;

    // final quotient and remainder with range check
    always_comb begin
        ovf = in_item.ovf_hi;
        if (in_item.is_signed) begin
            if (in_item.qneg) begin
                ovf = ovf || (in_item.lo > QNEG_MAX);
            end else begin
                ovf = ovf || (in_item.lo > QPOS_MAX);
            end
        end
        quot = in_item.qneg ? (WORD_W'(0) - in_item.lo) : in_item.lo;
        rem  = in_item.dneg ? (WORD_W'(0) - in_item.rem) : in_item.rem;

        result_next    = '0;
        write_reg_next = 1'b0;
        dz_next        = 1'b0;
        flags_next     = in_item.flags;
        if (in_item.dz) begin
            dz_next = 1'b1;
        end else if (ovf) begin
            flags_next[FLAG_V] = 1'b1;
            flags_next[FLAG_C] = 1'b0;
        end else begin
            result_next        = {rem, quot};
            write_reg_next     = 1'b1;
            flags_next         = '0;
            flags_next[FLAG_Z] = (quot == '0);
            flags_next[FLAG_N] = quot[WORD_W-1];
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            result_reg    <= result_next;
            write_reg_reg <= write_reg_next;
            flags_reg     <= flags_next;
            dz_reg        <= dz_next;
        end
    end

    assign out_valid      = valid_reg;
    assign result         = result_reg;
    assign write_reg      = write_reg_reg;
    assign flags_out      = flags_reg;
    assign divide_by_zero = dz_reg;

endmodule

@@ sv/word_divide_with_flags.sv @@
// top level: pipelined 32-by-16 unsigned and signed word divide with flags
// stages from accepted input word to output word:
//   1 operand stage, 8 division stages of 2 quotient bits, 1 output stage
// throughput: one word per cycle while m_tready is high; a stage takes a new word when empty or when its word moves on
// reset: synchronous active low aresetn clears all stage valid bits
module word_divide_with_flags
    import wdf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // dividend[31:0], divisor[47:32], flags_in[51:48], zero fill above
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // kind[0]
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // result[31:0], write_reg[32], flags_out[36:33], divide_by_zero[37], zero fill
    output logic [M_TDATA_W-1:0]  m_tdata
);

    logic       stg_valid [NUM_STEP_STAGES+1];
    logic       stg_ready [NUM_STEP_STAGES+1];
    wdf_item_t  stg_item  [NUM_STEP_STAGES+1];

    logic [LONG_W-1:0]   result;
    logic                write_reg;
    logic [FLAGS_W-1:0]  flags_out;
    logic                divide_by_zero;

    // operand stage
    wdf_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .kind      (s_tuser),
        .dividend  (s_tdata[LONG_W-1:0]),
        .divisor   (s_tdata[LONG_W+WORD_W-1:LONG_W]),
        .flags_in  (s_tdata[LONG_W+WORD_W+FLAGS_W-1:LONG_W+WORD_W]),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_item  (stg_item[0])
    );

    // division stages
    for (genvar g = 0; g < NUM_STEP_STAGES; g++) begin : g_step
        wdf_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_item   (stg_item[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_item  (stg_item[g+1])
        );
    end

    // output stage
    wdf_fin u_fin (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (stg_valid[NUM_STEP_STAGES]),
        .in_ready       (stg_ready[NUM_STEP_STAGES]),
        .in_item        (stg_item[NUM_STEP_STAGES]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .result         (result),
        .write_reg      (write_reg),
        .flags_out      (flags_out),
        .divide_by_zero (divide_by_zero)
    );

    // pack output word
    assign m_tdata = {2'b00, divide_by_zero, flags_out, write_reg, result};

endmodule

@@ tb/sv/tb.sv @@
// testbench for the pipelined 32-by-16 word divide with condition code flags
`timescale 1ns / 100ps

module tb
    import wdf_pkg::*;
();

    // one expected output word of the divider
    typedef struct packed {
        logic [LONG_W-1:0]  result;
        logic               write_reg;
        logic [FLAGS_W-1:0] flags;
        logic               div_zero;
    } div_outcome_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // dividend[31:0], divisor[47:32], flags_in[51:48], zero fill above
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // kind[0]
    logic                 s_tuser  = KIND_UNSIGNED;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // result[31:0], write_reg[32], flags_out[36:33], divide_by_zero[37], zero fill
    logic [M_TDATA_W-1:0] m_tdata;

    div_outcome_t outcome_fifo[$];
    int           mismatch_count = 0;
    logic         no_idle        = 1'b0;

    word_divide_with_flags u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // divide with truncation toward zero, remainder follows the dividend sign
    function automatic div_outcome_t predict_divide(logic kind, logic [LONG_W-1:0] dvd,
                                                    logic [WORD_W-1:0] dvs,
                                                    logic [FLAGS_W-1:0] flags);
        div_outcome_t      o;
        logic [LONG_W-1:0] mag_dvd;
        logic [WORD_W-1:0] mag_dvs;
        logic [LONG_W-1:0] mag_q;
        logic [LONG_W-1:0] mag_r;
        logic [WORD_W-1:0] quo;
        logic [WORD_W-1:0] rmd;
        logic              neg_dvd;
        logic              neg_q;
        logic              too_wide;
        o = '0;
        if (dvs == '0) begin
            o.flags    = flags;
            o.div_zero = 1'b1;
            return o;
        end
        if (kind == KIND_SIGNED) begin
            neg_dvd  = dvd[LONG_W-1];
            neg_q    = dvd[LONG_W-1] ^ dvs[WORD_W-1];
            mag_dvd  = neg_dvd ? -dvd : dvd;
            mag_dvs  = dvs[WORD_W-1] ? -dvs : dvs;
            mag_q    = mag_dvd / mag_dvs;
            mag_r    = mag_dvd % mag_dvs;
            too_wide = neg_q ? (mag_q > 32'h8000) : (mag_q > 32'h7fff);
            quo      = neg_q ? -mag_q[WORD_W-1:0] : mag_q[WORD_W-1:0];
            rmd      = neg_dvd ? -mag_r[WORD_W-1:0] : mag_r[WORD_W-1:0];
        end else begin
            mag_q    = dvd / dvs;
            mag_r    = dvd % dvs;
            too_wide = mag_q > 32'h0000ffff;
            quo      = mag_q[WORD_W-1:0];
            rmd      = mag_r[WORD_W-1:0];
        end
        if (too_wide) begin
            // overflow keeps N and Z, sets V, clears C, no register write
            o.flags[FLAG_N] = flags[FLAG_N];
            o.flags[FLAG_Z] = flags[FLAG_Z];
            o.flags[FLAG_V] = 1'b1;
            return o;
        end
        o.result        = {rmd, quo};
        o.write_reg     = 1'b1;
        o.flags[FLAG_Z] = (quo == '0);
        o.flags[FLAG_N] = quo[WORD_W-1];
        return o;
    endfunction

    // send one word after a random gap; called and returns at a falling edge
    task automatic send_divide(logic kind, logic [LONG_W-1:0] dvd, logic [WORD_W-1:0] dvs,
                               logic [FLAGS_W-1:0] flags);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, flags, dvs, dvd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        outcome_fifo.push_back(predict_divide(kind, dvd, dvs, flags));
        @(negedge aclk);
    endtask

    // build a dividend that yields the chosen quotient and a random remainder
    task automatic send_quotient(logic kind, int quot, logic [WORD_W-1:0] dvs);
        longint prod;
        int     d_val;
        int     d_mag;
        int     rem;
        d_val = (kind == KIND_SIGNED) ? int'($signed(dvs)) : int'(dvs);
        d_mag = (d_val < 0) ? -d_val : d_val;
        prod  = longint'(quot) * d_val;
        rem   = int'($urandom_range(0, d_mag - 1));
        if (prod < 0 || (prod == 0 && kind == KIND_SIGNED && $urandom_range(0, 1) == 1))
            rem = -rem;
        send_divide(kind, LONG_W'(prod + rem), dvs, FLAGS_W'($urandom_range(0, 15)));
    endtask

    function automatic logic [WORD_W-1:0] nonzero_divisor();
        return WORD_W'($urandom_range(1, 16'hffff));
    endfunction

    // divisor zero in both kinds, flags must pass through untouched
    task automatic test_zero_divisor();
        send_divide(KIND_UNSIGNED, 32'h0000_0000, 16'h0000, 4'h0);
        send_divide(KIND_UNSIGNED, 32'hffff_ffff, 16'h0000, 4'hf);
        send_divide(KIND_SIGNED,   32'h8000_0000, 16'h0000, 4'ha);
        send_divide(KIND_SIGNED,   32'h7fff_ffff, 16'h0000, 4'h5);
    endtask

    // unsigned quotient at and beyond the 16-bit limit
    task automatic test_unsigned_limits();
        send_divide(KIND_UNSIGNED, 32'h0000_0000, 16'h0001, 4'h3);
        send_divide(KIND_UNSIGNED, 32'h0000_0005, 16'h0007, 4'h8);
        send_divide(KIND_UNSIGNED, 32'h0000_ffff, 16'h0001, 4'h6);
        send_divide(KIND_UNSIGNED, 32'h0001_0000, 16'h0001, 4'hf);
        send_divide(KIND_UNSIGNED, 32'hfffe_ffff, 16'hffff, 4'h1);
        send_divide(KIND_UNSIGNED, 32'hffff_ffff, 16'hffff, 4'hc);
        send_divide(KIND_UNSIGNED, 32'hffff_ffff, 16'h0001, 4'h0);
    endtask

    // signed sign combinations and the quotient range edges
    task automatic test_signed_limits();
        send_divide(KIND_SIGNED, 32'h8000_0000, 16'hffff, 4'hd);
        send_divide(KIND_SIGNED, 32'h8000_0000, 16'h8000, 4'h4);
        send_divide(KIND_SIGNED, 32'hc000_0000, 16'h8000, 4'h9);
        send_divide(KIND_SIGNED, 32'hffff_8000, 16'h0001, 4'h2);
        send_divide(KIND_SIGNED, 32'h0000_8000, 16'hffff, 4'h7);
        send_divide(KIND_SIGNED, 32'h0000_7fff, 16'h0001, 4'h0);
        send_divide(KIND_SIGNED, 32'h0000_8000, 16'h0001, 4'hb);
        send_divide(KIND_SIGNED, 32'hffff_fff9, 16'h0002, 4'h1);
        send_divide(KIND_SIGNED, 32'h0000_0007, 16'hfffe, 4'he);
        send_divide(KIND_SIGNED, 32'hffff_fff9, 16'hfffe, 4'h3);
        send_divide(KIND_SIGNED, 32'h0000_0000, 16'hffff, 4'h8);
        send_divide(KIND_SIGNED, 32'h7fff_ffff, 16'h7fff, 4'h6);
        send_divide(KIND_SIGNED, 32'h8000_0000, 16'h7fff, 4'h5);
    endtask

    // mostly in-range quotients, plus boundary, raw random and zero divisors
    task automatic test_random_mix(int count);
        int          pick;
        logic        kind;
        logic [WORD_W-1:0] dvs;
        int          quot;
        for (int i = 0; i < count; i++) begin
            no_idle = ((i / 80) % 3 == 2);
            pick    = $urandom_range(0, 99);
            kind    = 1'($urandom_range(0, 1));
            if (pick < 60) begin
                dvs  = nonzero_divisor();
                quot = (kind == KIND_SIGNED) ? int'($urandom_range(0, 16'hffff)) - 32768
                                             : int'($urandom_range(0, 16'hffff));
                send_quotient(kind, quot, dvs);
            end else if (pick < 72) begin
                // quotient right at or just past the representable range
                if (kind == KIND_SIGNED) begin
                    dvs = WORD_W'($urandom_range(1, 16'h7fff));
                    if ($urandom_range(0, 1) == 1)
                        dvs = -dvs;
                    case ($urandom_range(0, 3))
                        0: quot = 32767;
                        1: quot = 32768;
                        2: quot = -32768;
                        default: quot = -32769;
                    endcase
                end else begin
                    dvs  = WORD_W'($urandom_range(1, 16'hfff0));
                    quot = 16'hffff + int'($urandom_range(0, 2));
                end
                send_quotient(kind, quot, dvs);
            end else if (pick < 95) begin
                send_divide(kind, $urandom, WORD_W'($urandom),
                            FLAGS_W'($urandom_range(0, 15)));
            end else begin
                send_divide(kind, $urandom, '0, FLAGS_W'($urandom_range(0, 15)));
            end
        end
        no_idle = 1'b0;
    endtask

    // result side back pressure, one random stall per output word
    initial begin : drain_results
        int stall;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    task automatic check_field(string name, logic [LONG_W-1:0] want, logic [LONG_W-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
        end
    endtask

    // compare each output word with the oldest prediction
    always @(posedge aclk) begin : check_results
        div_outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (outcome_fifo.size() == 0) begin
                mismatch_count++;
                $display("%0t unexpected word: expected none actual %h", $time, m_tdata);
            end else begin
                want = outcome_fifo.pop_front();
                check_field("result",         want.result,            m_tdata[31:0]);
                check_field("write_reg",      LONG_W'(want.write_reg), LONG_W'(m_tdata[32]));
                check_field("flags_out",      LONG_W'(want.flags),    LONG_W'(m_tdata[36:33]));
                check_field("divide_by_zero", LONG_W'(want.div_zero), LONG_W'(m_tdata[37]));
            end
        end
    end

    // run sequence
    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_zero_divisor();
        test_unsigned_limits();
        test_signed_limits();
        test_random_mix(650);
        s_tvalid <= 1'b0;
        while (outcome_fifo.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && outcome_fifo.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
sv/wdf_pkg.sv
sv/wdf_prep.sv
sv/wdf_step.sv
sv/wdf_fin.sv
sv/word_divide_with_flags.sv
tb/sv/tb.sv
